@@ rtl/core/mls_pkg.sv @@
`timescale 1ns / 1ps

package mls_pkg;

	localparam int MAX_LEGS = 8;
	localparam int IDX_W    = (MAX_LEGS > 1) ? $clog2(MAX_LEGS) : 1;
	localparam int CNT_W    = $clog2(MAX_LEGS + 1);

	localparam int KIND_W   = 2;
	localparam int LEG_W    = 3;
	localparam int WEIGHT_W = 16;
	localparam int RTT_W    = 32;
	localparam int SENT_W   = 32;
	localparam int STAT_W   = 2;
	localparam int PROD_W   = SENT_W + WEIGHT_W;
	localparam int CMP_W    = (CNT_W > LEG_W) ? CNT_W : LEG_W;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 8;

	localparam logic [WEIGHT_W-1:0] DEFAULT_WEIGHT = 16'd1000;
	localparam logic [SENT_W-1:0]   SENT_MAX       = '1;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_REJECT    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NONE_LEFT = 2'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD  = 2'd0,
		KIND_RTT  = 2'd1,
		KIND_SEND = 2'd2,
		KIND_FAIL = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_CMP,
		ST_SEND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic scan_start;
		logic mul;
		logic cmp;
		logic commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
	} dp_stat_t;

endpackage

@@ rtl/core/multipath_leg_scheduler.sv @@
`timescale 1ns / 1ps

// Channel   Ports              Direction  Contents
// -------   -----------------  ---------  ----------------------------------------
// input     s_axis_*           in         one command item (add, rtt, send, fail)
// output    m_axis_*           out        one result item for each command item
//
// Add, rtt and fail items go from capture through an exec state to the
// output register. A send item scans the table: the scan visits every
// table entry in a multiply state and a compare state through one shared
// pair of 32x16 multipliers, then commits the chosen leg.
// Reset clears the controller, the active flags, the slot count and scan state.
// The next item is taken as soon as the controller is idle, even while the
// previous result still waits in the output register; a stalled output
// holds the following result in the controller until the register frees.

module multipath_leg_scheduler
	import mls_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [2:0] leg, [18:3] weight, [50:19] rtt_sample, [55:51] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] kind
	input  logic [KIND_W-1:0]     s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [1:0] status, [4:2] chosen_leg, [7:5] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	cmd_t                cmd;
	dp_stat_t            stat;
	kind_t               kind;
	logic [LEG_W-1:0]    leg;
	logic [WEIGHT_W-1:0] weight;
	logic [RTT_W-1:0]    rtt_sample;
	logic [STAT_W-1:0]   status;
	logic [LEG_W-1:0]    chosen_leg;

	// unpack the input item
	assign kind       = kind_t'(s_axis_tuser);
	assign leg        = s_axis_tdata[LEG_W-1:0];
	assign weight     = s_axis_tdata[LEG_W+WEIGHT_W-1:LEG_W];
	assign rtt_sample = s_axis_tdata[LEG_W+WEIGHT_W+RTT_W-1:LEG_W+WEIGHT_W];

	// sequencer: one item at a time, scan loop for send items
	mls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_kind   (kind),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// leg table, srtt filter, scan compare and output register
	mls_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.kind       (kind),
		.leg        (leg),
		.weight     (weight),
		.rtt_sample (rtt_sample),
		.status     (status),
		.chosen_leg (chosen_leg)
	);

	// pack the result item, pad to a whole byte
	assign m_axis_tdata = {(OUT_DATA_W - STAT_W - LEG_W)'(0), chosen_leg, status};

endmodule

@@ rtl/core/mls_ctrl.sv @@
`timescale 1ns / 1ps

module mls_ctrl
	import mls_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  kind_t    in_kind,
	output logic     in_ready,
	input  logic     out_ready,
	output logic     out_valid,
	input  dp_stat_t stat,
	output cmd_t     cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   in_accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (in_kind == KIND_SEND) begin
						cmd.scan_start = 1'b1;
						state_d        = ST_MUL;
					end else begin
						state_d = ST_EXEC;
					end
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_DONE;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = stat.scan_last ? ST_SEND : ST_MUL;
			end
			ST_SEND: begin
				cmd.commit = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q != ST_IDLE))
		else $error("accepted item did not start work");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && stat.scan_last) |=> (state_q == ST_SEND))
		else $error("scan did not end in commit");

endmodule

@@ rtl/core/mls_dp.sv @@
`timescale 1ns / 1ps

module mls_dp
	import mls_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output dp_stat_t            stat,
	input  kind_t               kind,
	input  logic [LEG_W-1:0]    leg,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic [RTT_W-1:0]    rtt_sample,
	output logic [STAT_W-1:0]   status,
	output logic [LEG_W-1:0]    chosen_leg
);

	// captured item
	kind_t               kind_q;
	logic [LEG_W-1:0]    leg_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [RTT_W-1:0]    sample_q;

	// leg table
	logic [MAX_LEGS-1:0] active_q;
	logic [MAX_LEGS-1:0] rvalid_q;
	logic [WEIGHT_W-1:0] lweight_q [MAX_LEGS];
	logic [SENT_W-1:0]   sent_q    [MAX_LEGS];
	logic [RTT_W-1:0]    srtt_q    [MAX_LEGS];
	logic [CNT_W-1:0]    in_use_q;

	// scan state
	logic [IDX_W-1:0]    idx_q;
	logic                rfound_q;
	logic                wfound_q;
	logic [IDX_W-1:0]    rbest_idx_q;
	logic [RTT_W-1:0]    rbest_srtt_q;
	logic [SENT_W-1:0]   rbest_sent_q;
	logic [IDX_W-1:0]    wbest_idx_q;
	logic [SENT_W-1:0]   wbest_sent_q;
	logic [WEIGHT_W-1:0] wbest_w_q;

	// candidate stage
	logic                cand_act_s1;
	logic                cand_rv_s1;
	logic [IDX_W-1:0]    cand_idx_s1;
	logic [RTT_W-1:0]    cand_srtt_s1;
	logic [SENT_W-1:0]   cand_sent_s1;
	logic [WEIGHT_W-1:0] cand_w_s1;
	logic [PROD_W-1:0]   prod_c_s1;
	logic [PROD_W-1:0]   prod_b_s1;

	// result
	logic [STAT_W-1:0]   res_status_q;
	logic [LEG_W-1:0]    res_leg_q;
	logic [STAT_W-1:0]   out_status_q;
	logic [LEG_W-1:0]    out_leg_q;

	logic [IDX_W-1:0]    leg_idx;
	logic                leg_ok;
	logic [IDX_W-1:0]    rd_idx;
	logic [RTT_W-1:0]    rd_srtt;
	logic                rd_rv;
	logic                rd_act;
	logic [SENT_W-1:0]   rd_sent;
	logic [WEIGHT_W-1:0] rd_w;
	logic [RTT_W+2:0]    avg_sum;
	logic [RTT_W-1:0]    new_srtt;
	logic [MAX_LEGS-1:0] use_mask;
	logic                hole_found;
	logic [IDX_W-1:0]    hole_idx;
	logic                add_ok;
	logic                add_append;
	logic [IDX_W-1:0]    add_idx;
	logic [MAX_LEGS-1:0] others;
	logic                send_ok;
	logic [IDX_W-1:0]    sel_idx;
	logic [SENT_W-1:0]   sel_sent;
	logic [SENT_W-1:0]   sel_sent_inc;

	assign stat.scan_last = (idx_q == IDX_W'(MAX_LEGS - 1));

	always_comb begin
		leg_idx = IDX_W'(leg_q);
		leg_ok  = CMP_W'(leg_q) < CMP_W'(in_use_q);
		rd_idx  = cmd.mul ? idx_q : leg_idx;
		rd_srtt = srtt_q[rd_idx];
		rd_rv   = rvalid_q[rd_idx];
		rd_act  = active_q[rd_idx];
		rd_sent = sent_q[rd_idx];
		rd_w    = lweight_q[rd_idx];

		// (7*srtt + sample) / 8
		avg_sum  = {rd_srtt, 3'b000} - (RTT_W + 3)'(rd_srtt) + (RTT_W + 3)'(sample_q);
		new_srtt = rd_rv ? avg_sum[RTT_W+2:3] : sample_q;

		hole_found = 1'b0;
		hole_idx   = '0;
		for (int i = MAX_LEGS - 1; i >= 0; i--) begin
			use_mask[i] = CNT_W'(i) < in_use_q;
			if (use_mask[i] && !active_q[i]) begin
				hole_found = 1'b1;
				hole_idx   = IDX_W'(i);
			end
		end
		add_append = !hole_found && (in_use_q < CNT_W'(MAX_LEGS));
		add_ok     = hole_found || add_append;
		add_idx    = hole_found ? hole_idx : in_use_q[IDX_W-1:0];

		others = active_q & ~(leg_ok ? (MAX_LEGS'(1) << leg_idx) : '0);

		send_ok      = rfound_q || wfound_q;
		sel_idx      = rfound_q ? rbest_idx_q : wbest_idx_q;
		sel_sent     = rfound_q ? rbest_sent_q : wbest_sent_q;
		sel_sent_inc = (sel_sent == SENT_MAX) ? sel_sent : sel_sent + 1'b1;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			in_use_q <= '0;
			idx_q    <= '0;
			rfound_q <= 1'b0;
			wfound_q <= 1'b0;
		end else begin
			if (cmd.exec && kind_q == KIND_ADD && add_ok) begin
				active_q[add_idx] <= 1'b1;
				if (add_append) begin
					in_use_q <= in_use_q + 1'b1;
				end
			end
			if (cmd.exec && kind_q == KIND_FAIL && leg_ok) begin
				active_q[leg_idx] <= 1'b0;
			end
			if (cmd.scan_start) begin
				idx_q    <= '0;
				rfound_q <= 1'b0;
				wfound_q <= 1'b0;
			end
			if (cmd.cmp) begin
				idx_q <= idx_q + 1'b1;
				if (cand_act_s1 && cand_rv_s1 && (!rfound_q || cand_srtt_s1 < rbest_srtt_q)) begin
					rfound_q <= 1'b1;
				end
				if (cand_act_s1) begin
					wfound_q <= 1'b1;
				end
			end
		end
	end

	// table payload and scan datapath
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= kind;
			leg_q    <= leg;
			weight_q <= weight;
			sample_q <= rtt_sample;
		end
		if (cmd.exec && kind_q == KIND_ADD && add_ok) begin
			lweight_q[add_idx] <= (weight_q == '0) ? DEFAULT_WEIGHT : weight_q;
			sent_q[add_idx]    <= '0;
			rvalid_q[add_idx]  <= 1'b0;
			srtt_q[add_idx]    <= '0;
		end
		if (cmd.exec && kind_q == KIND_RTT && leg_ok) begin
			srtt_q[leg_idx]   <= new_srtt;
			rvalid_q[leg_idx] <= 1'b1;
		end
		if (cmd.commit && send_ok) begin
			sent_q[sel_idx] <= sel_sent_inc;
		end

		if (cmd.mul) begin
			cand_act_s1  <= rd_act;
			cand_rv_s1   <= rd_rv;
			cand_idx_s1  <= idx_q;
			cand_srtt_s1 <= rd_srtt;
			cand_sent_s1 <= rd_sent;
			cand_w_s1    <= rd_w;
			// sent_c / w_c < sent_b / w_b  <=>  sent_c * w_b < sent_b * w_c
			prod_c_s1    <= PROD_W'(rd_sent) * PROD_W'(wbest_w_q);
			prod_b_s1    <= PROD_W'(wbest_sent_q) * PROD_W'(rd_w);
		end
		if (cmd.cmp) begin
			if (cand_act_s1 && cand_rv_s1 && (!rfound_q || cand_srtt_s1 < rbest_srtt_q)) begin
				rbest_idx_q  <= cand_idx_s1;
				rbest_srtt_q <= cand_srtt_s1;
				rbest_sent_q <= cand_sent_s1;
			end
			if (cand_act_s1 && (!wfound_q || prod_c_s1 < prod_b_s1)) begin
				wbest_idx_q  <= cand_idx_s1;
				wbest_sent_q <= cand_sent_s1;
				wbest_w_q    <= cand_w_s1;
			end
		end

		if (cmd.exec) begin
			case (kind_q)
				KIND_ADD: begin
					res_status_q <= add_ok ? STAT_OK : STAT_REJECT;
					res_leg_q    <= add_ok ? LEG_W'(add_idx) : '0;
				end
				KIND_RTT: begin
					res_status_q <= leg_ok ? STAT_OK : STAT_REJECT;
					res_leg_q    <= '0;
				end
				KIND_FAIL: begin
					res_status_q <= (others == '0) ? STAT_NONE_LEFT : STAT_OK;
					res_leg_q    <= '0;
				end
				default: begin
					res_status_q <= STAT_REJECT;
					res_leg_q    <= '0;
				end
			endcase
		end
		if (cmd.commit) begin
			res_status_q <= send_ok ? STAT_OK : STAT_REJECT;
			res_leg_q    <= send_ok ? LEG_W'(sel_idx) : '0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_leg_q    <= res_leg_q;
		end
	end

	assign status     = out_status_q;
	assign chosen_leg = out_leg_q;

	a_use_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_use_q <= CNT_W'(MAX_LEGS))
		else $error("slot count past table size");

	a_active_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q & ~use_mask) == '0)
		else $error("active leg outside used slots");

	a_use_grows: assert property (@(posedge clk) disable iff (!arst_n)
		in_use_q >= $past(in_use_q))
		else $error("slot count went down");

endmodule
